// ===== sv/gregorian_date_evaluator_assert.svh =====
// Assertion macros shared by the date evaluator RTL.
`ifndef GREGORIAN_DATE_EVALUATOR_ASSERT_SVH
`define GREGORIAN_DATE_EVALUATOR_ASSERT_SVH

// Implication in the same cycle.
`define GDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define GDE_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== sv/gde_pkg.sv =====
// Shared widths, constants and stage types of the date evaluator.
`timescale 1ns / 1ps
package gde_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

  // year / 100 by reciprocal: exact for every 14-bit year
  localparam int              RECIP_100_W     = 13;
  localparam logic [12:0]     RECIP_100       = 13'd5243;
  localparam int              RECIP_100_SHIFT = 19;
  localparam int              PROD100_W       = YEAR_W + RECIP_100_W;
  localparam int              Q100_W          = PROD100_W - RECIP_100_SHIFT;

  localparam int DB_W   = 23;
  localparam int WSUM_W = 15;
  localparam int DOY_W  = 9;

  // weekday sum / 7 by reciprocal, quotient at most one too high
  localparam int          RECIP_7_W     = 14;
  localparam logic [13:0] RECIP_7       = 14'd9363;
  localparam int          RECIP_7_SHIFT = 16;
  localparam int          PROD7_W       = WSUM_W + RECIP_7_W;
  localparam int          Q7_W          = PROD7_W - RECIP_7_SHIFT;

  localparam int TO_MONTH_W = 6;
  localparam int TO_YEAR_W  = 10;
  localparam int DIFF_W     = 23;
  localparam int DIFF_EXT_W = DB_W + 2;

  localparam logic signed [DIFF_EXT_W-1:0] DIFF_HI = DIFF_EXT_W'(2**(DIFF_W-1) - 1);
  localparam logic signed [DIFF_EXT_W-1:0] DIFF_LO = -DIFF_HI - DIFF_EXT_W'(1);

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t start_date;
    date_t end_date;
    logic  include_end;
  } s1_t;

  typedef struct packed {
    logic [WSUM_W-1:0] wsum;
    logic [DOY_W-1:0]  doy;
    logic [DOY_W-1:0]  end_doy;
    logic              leap;
    logic [DAY_W-1:0]  mlen;
    logic [DAY_W-1:0]  day;
    logic [DB_W-1:0]   db_start;
    logic [DB_W-1:0]   db_end;
    logic              include_end;
  } s3_t;

endpackage

// ===== sv/gde_input.sv =====
// Input stage: field clamping and first pipeline register.
`timescale 1ns / 1ps
module gde_input import gde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  input  logic [YEAR_W-1:0]  end_year,
  input  logic [MONTH_W-1:0] end_month,
  input  logic [DAY_W-1:0]   end_day,
  input  logic               include_end,
  output logic               s1_valid,
  output s1_t                s1
);

  function automatic date_t fix_date(input logic [YEAR_W-1:0] y,
                                     input logic [MONTH_W-1:0] m,
                                     input logic [DAY_W-1:0] d);
    date_t r;
    priority if (y == '0)      r.year = YEAR_W'(1);
    else if (y > MAX_YEAR)     r.year = MAX_YEAR;
    else                       r.year = y;
    priority if (m == '0)          r.month = MONTH_W'(1);
    else if (m > MONTH_W'(12))     r.month = MONTH_W'(12);
    else                           r.month = m;
    r.day = (d == '0) ? DAY_W'(1) : d;
    return r;
  endfunction

  s1_t s1_next;

  always_comb begin
    s1_next.start_date  = fix_date(year, month, day);
    s1_next.end_date    = fix_date(end_year, end_month, end_day);
    s1_next.include_end = include_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1 <= s1_next;
    end
  end

endmodule

// ===== sv/gde_calendar.sv =====
// Calendar stages: century quotients, leap years, day counts, weekday sum.
`timescale 1ns / 1ps
module gde_calendar import gde_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s1_valid,
  input  s1_t  s1,
  output logic s3_valid,
  output s3_t  s3
);

  typedef struct packed {
    logic              leap;
    logic [Q100_W-1:0] zq100;
    logic [DB_W-1:0]   days_before;
  } year_info_t;

  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      MONTH_W'(1):  r = DOY_W'(0);
      MONTH_W'(2):  r = DOY_W'(31);
      MONTH_W'(3):  r = DOY_W'(59);
      MONTH_W'(4):  r = DOY_W'(90);
      MONTH_W'(5):  r = DOY_W'(120);
      MONTH_W'(6):  r = DOY_W'(151);
      MONTH_W'(7):  r = DOY_W'(181);
      MONTH_W'(8):  r = DOY_W'(212);
      MONTH_W'(9):  r = DOY_W'(243);
      MONTH_W'(10): r = DOY_W'(273);
      MONTH_W'(11): r = DOY_W'(304);
      default:      r = DOY_W'(334);
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    unique case (m)
      MONTH_W'(2):  r = DAY_W'(28);
      MONTH_W'(4),
      MONTH_W'(6),
      MONTH_W'(9),
      MONTH_W'(11): r = DAY_W'(30);
      default:      r = DAY_W'(31);
    endcase
    return r;
  endfunction

  // (31 * shifted month) / 12, March as month one
  function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    unique case (m)
      MONTH_W'(1):  r = DAY_W'(28);
      MONTH_W'(2):  r = DAY_W'(31);
      MONTH_W'(3):  r = DAY_W'(2);
      MONTH_W'(4):  r = DAY_W'(5);
      MONTH_W'(5):  r = DAY_W'(7);
      MONTH_W'(6):  r = DAY_W'(10);
      MONTH_W'(7):  r = DAY_W'(12);
      MONTH_W'(8):  r = DAY_W'(15);
      MONTH_W'(9):  r = DAY_W'(18);
      MONTH_W'(10): r = DAY_W'(20);
      MONTH_W'(11): r = DAY_W'(23);
      default:      r = DAY_W'(25);
    endcase
    return r;
  endfunction

  // q is year / 100; quotients of year - 1 follow from it
  function automatic year_info_t year_info(input logic [YEAR_W-1:0] y,
                                           input logic [Q100_W-1:0] q);
    logic [YEAR_W-1:0] r100;
    logic [YEAR_W-1:0] z;
    logic              century;
    year_info_t        info;
    r100    = y - YEAR_W'(q) * YEAR_W'(100);
    century = (r100 == '0);
    z       = y - YEAR_W'(1);
    info.leap        = century ? (q[1:0] == 2'b00) : (y[1:0] == 2'b00);
    info.zq100       = q - Q100_W'(century);
    info.days_before = DB_W'(z) * DB_W'(365) + DB_W'(z >> 2)
                     - DB_W'(info.zq100) + DB_W'(info.zq100 >> 2);
    return info;
  endfunction

  // stage 2
  logic                 s2_valid;
  s1_t                  s2;
  logic [Q100_W-1:0]    s2_q_start;
  logic [Q100_W-1:0]    s2_q_end;
  logic [PROD100_W-1:0] prod_start;
  logic [PROD100_W-1:0] prod_end;

  assign prod_start = PROD100_W'(s1.start_date.year) * PROD100_W'(RECIP_100);
  assign prod_end   = PROD100_W'(s1.end_date.year) * PROD100_W'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2         <= s1;
      s2_q_start <= prod_start[RECIP_100_SHIFT +: Q100_W];
      s2_q_end   <= prod_end[RECIP_100_SHIFT +: Q100_W];
    end
  end

  // stage 3
  year_info_t        info_start;
  year_info_t        info_end;
  logic              jan_feb;
  logic [YEAR_W-1:0] yy;
  logic [Q100_W-1:0] yy_q100;
  s3_t               s3_next;

  always_comb begin
    info_start = year_info(s2.start_date.year, s2_q_start);
    info_end   = year_info(s2.end_date.year, s2_q_end);
    jan_feb    = (s2.start_date.month < MONTH_W'(3));
    yy         = s2.start_date.year - YEAR_W'(jan_feb);
    yy_q100    = jan_feb ? info_start.zq100 : s2_q_start;

    s3_next.wsum = WSUM_W'(s2.start_date.day) + WSUM_W'(yy) + WSUM_W'(yy >> 2)
                 - WSUM_W'(yy_q100) + WSUM_W'(yy_q100 >> 2)
                 + WSUM_W'(month_offset(s2.start_date.month));
    s3_next.doy = cum_days(s2.start_date.month) + DOY_W'(s2.start_date.day)
                + DOY_W'((s2.start_date.month > MONTH_W'(2)) && info_start.leap);
    s3_next.end_doy = cum_days(s2.end_date.month) + DOY_W'(s2.end_date.day)
                    + DOY_W'((s2.end_date.month > MONTH_W'(2)) && info_end.leap);
    s3_next.leap = info_start.leap;
    s3_next.mlen = month_len(s2.start_date.month)
                 + DAY_W'((s2.start_date.month == MONTH_W'(2)) && info_start.leap);
    s3_next.day         = s2.start_date.day;
    s3_next.db_start    = info_start.days_before;
    s3_next.db_end      = info_end.days_before;
    s3_next.include_end = s2.include_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3 <= s3_next;
    end
  end

endmodule

// ===== sv/gde_finish.sv =====
// Finish stages: weekday modulo, differences, saturation, result register.
`timescale 1ns / 1ps
module gde_finish import gde_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s3_valid,
  input  s3_t                          s3,
  output logic                         done,
  output logic [2:0]                   weekday,
  output logic                         last_of_week,
  output logic                         weekend,
  output logic                         business_day,
  output logic [2:0]                   to_week_end,
  output logic signed [TO_MONTH_W-1:0] to_month_end,
  output logic signed [TO_YEAR_W-1:0]  to_year_end,
  output logic [DOY_W-1:0]             day_of_year,
  output logic                         leap,
  output logic signed [DIFF_W-1:0]     days_between
);

  // stage 4
  logic                   s4_valid;
  logic [WSUM_W-1:0]      s4_wsum;
  logic [Q7_W-1:0]        s4_q7;
  logic [TO_MONTH_W-1:0]  s4_to_month;
  logic [TO_YEAR_W-1:0]   s4_to_year;
  logic [DOY_W-1:0]       s4_doy;
  logic                   s4_leap;
  logic [DIFF_EXT_W-1:0]  s4_diff;
  logic [PROD7_W-1:0]     prod7;
  logic [DIFF_EXT_W-1:0]  diff_next;

  assign prod7 = PROD7_W'(s3.wsum) * PROD7_W'(RECIP_7);
  assign diff_next = DIFF_EXT_W'(s3.db_end) - DIFF_EXT_W'(s3.db_start)
                   + DIFF_EXT_W'(s3.end_doy) - DIFF_EXT_W'(s3.doy)
                   + DIFF_EXT_W'(s3.include_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      s4_wsum     <= s3.wsum;
      s4_q7       <= prod7[RECIP_7_SHIFT +: Q7_W];
      s4_to_month <= TO_MONTH_W'(s3.mlen) - TO_MONTH_W'(s3.day) + TO_MONTH_W'(1);
      s4_to_year  <= TO_YEAR_W'(s3.leap ? 366 : 365) - TO_YEAR_W'(s3.doy)
                   + TO_YEAR_W'(1);
      s4_doy      <= s3.doy;
      s4_leap     <= s3.leap;
      s4_diff     <= diff_next;
    end
  end

  // stage 5: remainder in -7..6 held mod 16, one correction step
  logic [3:0]        rem;
  logic [2:0]        wd;
  logic [DIFF_W-1:0] diff_sat;

  always_comb begin
    rem = s4_wsum[3:0] - 4'(s4_q7 * Q7_W'(7));
    wd  = rem[3] ? 3'(rem + 4'd7) : rem[2:0];
    priority if ($signed(s4_diff) > DIFF_HI) diff_sat = DIFF_HI[DIFF_W-1:0];
    else if ($signed(s4_diff) < DIFF_LO)     diff_sat = DIFF_LO[DIFF_W-1:0];
    else                                     diff_sat = s4_diff[DIFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid) begin
      weekday      <= wd;
      last_of_week <= (wd == 3'd6);
      weekend      <= (wd == 3'd5) || (wd == 3'd6);
      business_day <= !((wd == 3'd5) || (wd == 3'd6));
      to_week_end  <= 3'd6 - wd;
      to_month_end <= s4_to_month;
      to_year_end  <= s4_to_year;
      day_of_year  <= s4_doy;
      leap         <= s4_leap;
      days_between <= diff_sat;
    end
  end

endmodule

// ===== sv/gregorian_date_evaluator.sv =====
// A transfer on start reaches done via the s1, s2, s3, s4 and result registers.
// Throughput: one item every cycle; five register stages, the widest being the
// year / 100 and weekday / 7 reciprocal multiplies. busy is never raised.
// Results cannot be held off by the receiver; nothing needs stalling.
// Reset (synchronous, rst high) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
`include "gregorian_date_evaluator_assert.svh"
module gregorian_date_evaluator import gde_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [YEAR_W-1:0]            year,
  input  logic [MONTH_W-1:0]           month,
  input  logic [DAY_W-1:0]             day,
  input  logic [YEAR_W-1:0]            end_year,
  input  logic [MONTH_W-1:0]           end_month,
  input  logic [DAY_W-1:0]             end_day,
  input  logic                         include_end,
  output logic                         done,
  output logic [2:0]                   weekday,
  output logic                         last_of_week,
  output logic                         weekend,
  output logic                         business_day,
  output logic [2:0]                   to_week_end,
  output logic signed [TO_MONTH_W-1:0] to_month_end,
  output logic signed [TO_YEAR_W-1:0]  to_year_end,
  output logic [DOY_W-1:0]             day_of_year,
  output logic                         leap,
  output logic signed [DIFF_W-1:0]     days_between
);

  logic s1_valid;
  s1_t  s1;
  logic s3_valid;
  s3_t  s3;

  assign busy = 1'b0;

  gde_input u_input (
    .clk         (clk),
    .rst         (rst),
    .start       (start && !busy),
    .year        (year),
    .month       (month),
    .day         (day),
    .end_year    (end_year),
    .end_month   (end_month),
    .end_day     (end_day),
    .include_end (include_end),
    .s1_valid    (s1_valid),
    .s1          (s1)
  );

  gde_calendar u_calendar (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  gde_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .s3_valid     (s3_valid),
    .s3           (s3),
    .done         (done),
    .weekday      (weekday),
    .last_of_week (last_of_week),
    .weekend      (weekend),
    .business_day (business_day),
    .to_week_end  (to_week_end),
    .to_month_end (to_month_end),
    .to_year_end  (to_year_end),
    .day_of_year  (day_of_year),
    .leap         (leap),
    .days_between (days_between)
  );

  `GDE_ASSERT_DELAY(a_latency, start && !busy, 5, done, "transfer lost in pipeline")
  `GDE_ASSERT_NOW(a_no_extra, done, $past(start && !busy, 5), "result without transfer")
  `GDE_ASSERT_NOW(a_week_split, done, (4'(weekday) + 4'(to_week_end)) == 4'd6,
                  "weekday and days to week end disagree")
  `GDE_ASSERT_NOW(a_flags, done, (business_day != weekend) && (!last_of_week || weekend),
                  "weekday flags inconsistent")
  `GDE_ASSERT_NOW(a_year_split, done,
                  (TO_YEAR_W'(day_of_year) + to_year_end) == TO_YEAR_W'(leap ? 367 : 366),
                  "day of year and days to year end disagree")

endmodule
